// ===== sv/zscore_normalize_saturate_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the z-score core checker.
// ---------------------------------------------------------------------------
`ifndef ZSCORE_NORMALIZE_SATURATE_CORE_MACROS_SVH
`define ZSCORE_NORMALIZE_SATURATE_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ZS_ASSERT_IMP(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define ZS_ASSERT_NEXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== sv/zns_pkg.sv =====
// ---------------------------------------------------------------------------
// zns_pkg
// Widths, constants and shared types of the z-score core.
// ---------------------------------------------------------------------------
package zns_pkg;

  localparam int unsigned MaxValuesDef    = 1024;
  localparam int unsigned FractionBitsDef = 8;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned IndexW          = 10;
  localparam int unsigned ScaleW          = 16;
  localparam int unsigned NormW           = 16;
  localparam logic [ScaleW-1:0] ScaleReset = 16'd1000;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncRead = 1'b1;

  typedef struct packed {
    logic       start;
    logic [6:0] unused;
  } zns_ctl_t;

endpackage

// ===== sv/zns_ram.sv =====
// ---------------------------------------------------------------------------
// zns_ram
// Generic single-port synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
module zns_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== sv/zns_divsqrt.sv =====
// ---------------------------------------------------------------------------
// zns_divsqrt
// Bit-serial unsigned divider and integer square root, one step per cycle.
// ---------------------------------------------------------------------------
module zns_divsqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         div_start_i,
  input  logic         sqrt_i,
  input  logic [127:0] num_i,
  input  logic [63:0]  den_i,
  output logic         busy_o,
  output logic [63:0]  quot_o
);
  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, mode_q, mode_d;
  logic [127:0] num_q, num_d;
  logic [64:0]  rem_q, rem_d;
  logic [63:0]  den_q, den_d, quot_q, quot_d;
  logic [65:0]  trial;
  logic [64:0]  shifted;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; mode_d = mode_q;
    num_d = num_q; rem_d = rem_q; den_d = den_q; quot_d = quot_q;
    shifted = '0;
    trial = '0;
    if (div_start_i) begin
      busy_d = 1'b1; mode_d = sqrt_i; num_d = num_i; den_d = den_i;
      quot_d = '0;
      if (sqrt_i) begin
        rem_d = '0; cnt_d = 7'd32;
      end else begin
        rem_d = {1'b0, num_i[127:64]}; cnt_d = 7'd64;
      end
    end else if (busy_q) begin
      if (mode_q) begin
        trial = {rem_q[63:0], num_q[63:62]} - {quot_q[63:0], 2'b01};
        if (!trial[65]) begin
          rem_d = trial[64:0];
          quot_d = {quot_q[62:0], 1'b1};
        end else begin
          rem_d = {rem_q[62:0], num_q[63:62]};
          quot_d = {quot_q[62:0], 1'b0};
        end
        num_d = {num_q[125:0], 2'b00};
      end else begin
        shifted = {rem_q[63:0], num_q[63]};
        if (shifted >= {1'b0, den_q}) begin
          rem_d = shifted - {1'b0, den_q};
          quot_d = {quot_q[62:0], 1'b1};
        end else begin
          rem_d = shifted;
          quot_d = {quot_q[62:0], 1'b0};
        end
        num_d = {num_q[126:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; mode_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; quot_q <= quot_d;
  end

  assign busy_o = busy_q | div_start_i;
  assign quot_o = quot_q;
endmodule

// ===== sv/zns_sdiv.sv =====
// ---------------------------------------------------------------------------
// zns_sdiv
// Bit-serial signed divider truncating toward zero, one bit per cycle.
// ---------------------------------------------------------------------------
module zns_sdiv (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [49:0] num_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [49:0] quot_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d;
  logic [49:0] num_q, num_d, quot_q, quot_d;
  logic [32:0] rem_q, rem_d, sh;
  logic [31:0] den_q, den_d;
  logic        done_q, done_d;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; neg_d = neg_q; num_d = num_q;
    quot_d = quot_q; rem_d = rem_q; den_d = den_q; done_d = 1'b0;
    sh = '0;
    if (start_i) begin
      busy_d = 1'b1; neg_d = num_i[49]; den_d = den_i; rem_d = '0; quot_d = '0;
      num_d = num_i[49] ? 50'(-num_i) : 50'(num_i);
      cnt_d = 6'd50;
    end else if (busy_q) begin
      sh = {rem_q[31:0], num_q[49]};
      if (sh >= {1'b0, den_q}) begin
        rem_d = sh - {1'b0, den_q}; quot_d = {quot_q[48:0], 1'b1};
      end else begin
        rem_d = sh; quot_d = {quot_q[48:0], 1'b0};
      end
      num_d = {num_q[48:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d; busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; num_q <= num_d; quot_q <= quot_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quot_q) : $signed(quot_q);
endmodule

// ===== sv/zscore_normalize_saturate_core.sv =====
// ---------------------------------------------------------------------------
// zscore_normalize_saturate_core
// Loads a set of fixed-point values into a RAM and returns standardized,
// scaled and saturated values on read items.
// ---------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata {index, value}, tuser func, tlast last
// m_axis    out  tdata normalized, tuser status
// cfg       in   output_scale write
// A load without last leaves the core idle. A last load runs a summing pass, a
// 64-step divide for the mean, a deviation pass, a 64-step divide and a 32-step
// root over the stored values. A read of a stored value passes StRdWait and
// StRdMul, the 50-step serial divider and a result register before the output.
// No clearing pass after reset. One result may wait on the output without
// stalling the input; a second one behind it stalls it.
module zscore_normalize_saturate_core #(
  parameter int unsigned MaxValues    = zns_pkg::MaxValuesDef,
  parameter int unsigned FractionBits = zns_pkg::FractionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // value[31:0], index[41:32], zero fill
  input  logic        s_axis_tuser,   // func
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // normalized[15:0]
  output logic        m_axis_tuser,   // status
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import zns_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxValues);
  localparam int unsigned CntW  = AddrW + 1;

  typedef enum logic [3:0] {
    StIdle, StClear, StSumRd, StSumAcc, StMean, StVarRd, StVarAcc, StDiv, StDivW,
    StSqrt, StSqrtW, StRdWait, StRdMul, StRdDiv
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q, ptr_q;
  logic              complete_q;
  logic signed [31:0] mean_q;
  logic [31:0]       dev_q;
  logic [15:0]       scale_q;
  logic signed [63:0] sum_q;
  logic [127:0]      sq_q;
  logic [15:0]       out_data_q, res_data_q;
  logic              out_stat_q, out_valid_q, res_stat_q, res_valid_q;
  logic [AddrW-1:0]  ram_addr;
  logic              ram_we;
  logic [31:0]       ram_rdata;
  logic              du_start, du_sqrt, du_busy;
  logic [127:0]      du_num;
  logic [63:0]       du_den, du_quot;
  logic              sd_start, sd_done;
  logic signed [49:0] sd_num, sd_quot;
  logic signed [32:0] diff_q;
  logic [32:0]       mag;
  logic [65:0]       sq;
  logic              accept;
  logic              sd_busy_q;
  logic signed [63:0] mean_full;
  logic signed [63:0] sum_abs;
  logic [63:0]       q_abs;

  assign s_axis_tready = (state_q == StIdle) && !res_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ram_we = 1'b0;
    ram_addr = ptr_q[AddrW-1:0];
    if (accept && s_axis_tuser == FuncLoad) begin
      ram_addr = complete_q ? '0 : count_q[AddrW-1:0];
      ram_we = complete_q || (count_q < CntW'(MaxValues));
    end else if (accept) begin
      ram_addr = AddrW'(s_axis_tdata[32 +: IndexW]);
    end else if (state_q == StVarAcc && sd_busy_q) begin
      ram_addr = AddrW'(ptr_q + CntW'(1));
    end
  end

  zns_ram #(.Width(ValueW), .Depth(MaxValues)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(s_axis_tdata[31:0]),
    .rdata_o(ram_rdata)
  );

  assign mag = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
  assign sq  = 66'(mag) * 66'(mag);
  assign sum_abs = sum_q[63] ? -sum_q : sum_q;

  zns_divsqrt u_divsqrt (
    .clk_i, .rst_ni, .div_start_i(du_start), .sqrt_i(du_sqrt),
    .num_i(du_num), .den_i(du_den), .busy_o(du_busy), .quot_o(du_quot)
  );

  assign sd_num = 50'(diff_q) * $signed({34'd0, scale_q});
  zns_sdiv u_sdiv (
    .clk_i, .rst_ni, .start_i(sd_start), .num_i(sd_num), .den_i(dev_q),
    .done_o(sd_done), .quot_o(sd_quot)
  );

  always_comb begin
    du_start = 1'b0; du_sqrt = 1'b0;
    du_num = {64'd0, 64'(sum_abs)};
    du_den = 64'(count_q);
    sd_start = (state_q == StRdMul);
    unique case (state_q)
      StMean: du_start = 1'b1;
      StDiv: begin
        du_start = 1'b1; du_num = sq_q;
      end
      StSqrt: begin
        du_start = 1'b1; du_sqrt = 1'b1; du_num = {64'd0, du_quot};
      end
      default: ;
    endcase
    mean_full = sum_q[63] ? -$signed(du_quot) : $signed(du_quot);
    q_abs = du_quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; count_q <= '0; ptr_q <= '0; complete_q <= 1'b0;
      mean_q <= '0; dev_q <= 32'(1) << FractionBits; scale_q <= ScaleReset;
      sum_q <= '0; sq_q <= '0; sd_busy_q <= 1'b0;
      out_valid_q <= 1'b0; out_data_q <= '0; out_stat_q <= 1'b0;
      res_valid_q <= 1'b0; res_data_q <= '0; res_stat_q <= 1'b0;
    end else begin
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      if (res_valid_q && (!out_valid_q || m_axis_tready)) begin
        out_data_q <= res_data_q; out_stat_q <= res_stat_q; out_valid_q <= 1'b1;
        res_valid_q <= 1'b0;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: if (accept) begin
          if (s_axis_tuser == FuncLoad) begin
            if (complete_q) begin
              count_q <= CntW'(1);
              complete_q <= 1'b0;
            end else if (count_q < CntW'(MaxValues)) begin
              count_q <= count_q + CntW'(1);
            end
            if (s_axis_tlast) state_q <= StClear;
          end else if (!complete_q ||
                       {6'd0, s_axis_tdata[32 +: IndexW]} >= 16'(count_q)) begin
            res_data_q <= '0; res_stat_q <= 1'b1; res_valid_q <= 1'b1;
          end else begin
            state_q <= StRdWait;
          end
        end
        StClear: begin
          ptr_q <= '0; sum_q <= '0; sq_q <= '0;
          if (count_q == '0) begin
            mean_q <= '0; dev_q <= 32'(1) << FractionBits;
            complete_q <= 1'b1; state_q <= StIdle;
          end else begin
            state_q <= StSumRd;
          end
        end
        StSumRd: state_q <= StSumAcc;
        StSumAcc: begin
          sum_q <= sum_q + 64'(signed'(ram_rdata));
          ptr_q <= ptr_q + CntW'(1);
          state_q <= (ptr_q + CntW'(1) == count_q) ? StMean : StSumRd;
        end
        StMean: begin
          state_q <= StVarRd; ptr_q <= '0;
        end
        StVarRd: begin
          if (!du_busy) begin
            mean_q <= 32'(mean_full);
            state_q <= StVarAcc;
          end
        end
        StVarAcc: begin
          sd_busy_q <= !sd_busy_q;
          if (sd_busy_q) begin
            sq_q <= sq_q + 128'(sq);
            ptr_q <= ptr_q + CntW'(1);
            state_q <= (ptr_q + CntW'(1) == count_q) ? StDiv : StVarAcc;
          end
        end
        StDiv: state_q <= StDivW;
        StDivW: if (!du_busy) state_q <= StSqrt;
        StSqrt: state_q <= StSqrtW;
        StSqrtW: begin
          if (!du_busy) begin
            state_q <= StIdle; complete_q <= 1'b1;
            if (sq_q == '0) dev_q <= 32'(1) << FractionBits;
            else if (q_abs == '0) dev_q <= 32'd1;
            else dev_q <= q_abs[31:0];
          end
        end
        StRdWait: state_q <= StRdMul;
        StRdMul: state_q <= StRdDiv;
        StRdDiv: if (sd_done) begin
          res_stat_q <= 1'b0; res_valid_q <= 1'b1; state_q <= StIdle;
          res_data_q <= (sd_quot > 50'sd32767) ? 16'h7fff :
                        (sd_quot < -50'sd32768) ? 16'h8000 : sd_quot[15:0];
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StRdWait || (state_q == StVarAcc && !sd_busy_q)) begin
      diff_q <= 33'(signed'(ram_rdata)) - 33'(mean_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;
endmodule

// ===== sv/zns_checker.sv =====
// ---------------------------------------------------------------------------
// zns_checker
// Port-level checks of the z-score core.
// ---------------------------------------------------------------------------
`include "zscore_normalize_saturate_core_macros.svh"
module zns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  `ZS_ASSERT_NEXT(in_holds, clk_i, rst_ni, s_axis_tvalid && !s_axis_tready, s_axis_tvalid)
  `ZS_ASSERT_IMP(err_is_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                 m_axis_tdata == 16'd0)
  `ZS_ASSERT_NEXT(out_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
endmodule

bind zscore_normalize_saturate_core zns_checker u_zns_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

// ===== dv/zscore_normalize_saturate_core_tb.sv =====
// ---------------------------------------------------------------------------
// zscore_normalize_saturate_core_tb
// Streams load and read items into the z-score core under several flow
// control phases and scale settings, predicts every read result and checks
// each output item against the oldest prediction.
// ---------------------------------------------------------------------------
module zscore_normalize_saturate_core_tb;
  import zns_pkg::*;

  typedef struct packed {
    logic              func;
    logic [ValueW-1:0] value;
    logic              last;
    logic [IndexW-1:0] index;
  } zs_item_t;

  typedef struct packed {
    logic [NormW-1:0] norm;
    logic             status;
  } zs_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  zscore_normalize_saturate_core dut (.*);

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  zs_item_t   pending_items[$];
  zs_result_t expected_results[$];
  int         send_idle_pct, recv_idle_pct;
  int         errors;
  longint     cycle_count;
  bit         hold_send;

  // Predictor state.
  logic signed [31:0] st_values[MaxValuesDef];
  int unsigned        st_count;
  logic signed [31:0] st_mean;
  logic [31:0]        st_dev;
  bit                 st_complete;
  logic [15:0]        st_scale;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic compute_stats();
    logic signed [63:0] sum, d;
    logic [127:0]       sq_sum;
    logic [63:0]        quot, r;
    if (st_count == 0) begin
      st_mean = 0;
      st_dev  = 32'd1 << FractionBitsDef;
      return;
    end
    sum = 0;
    for (int i = 0; i < st_count; i++) sum += 64'(st_values[i]);
    st_mean = 32'(sum / $signed(64'(st_count)));
    sq_sum = 0;
    for (int i = 0; i < st_count; i++) begin
      d = 64'(st_values[i]) - 64'(st_mean);
      if (d < 0) d = -d;
      sq_sum += 128'(d) * 128'(d);
    end
    if (sq_sum == 0) begin
      st_dev = 32'd1 << FractionBitsDef;
      return;
    end
    quot = 64'(sq_sum / 128'(st_count));
    r = root64(quot);
    st_dev = (r == 0) ? 32'd1 : 32'(r);
  endtask

  task automatic predict_item(zs_item_t it);
    logic signed [63:0] d, p, q;
    zs_result_t res;
    if (it.func == FuncLoad) begin
      if (st_complete) begin
        st_count    = 0;
        st_complete = 0;
      end
      if (st_count < MaxValuesDef) begin
        st_values[st_count] = it.value;
        st_count++;
      end
      if (it.last) begin
        compute_stats();
        st_complete = 1;
      end
      return;
    end
    if (!st_complete || it.index >= st_count) begin
      res.norm   = 0;
      res.status = 1'b1;
    end else begin
      d = 64'(st_values[it.index]) - 64'(st_mean);
      p = d * $signed({48'd0, st_scale});
      q = p / $signed({32'd0, st_dev});
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      res.norm   = q[15:0];
      res.status = 1'b0;
    end
    expected_results.push_back(res);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_item({s_axis_tuser,
          s_axis_tdata[31:0], s_axis_tlast, s_axis_tdata[41:32]});
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          zs_item_t it;
          it = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, it.index, it.value};
          s_axis_tuser  <= it.func;
          s_axis_tlast  <= it.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result norm %0d status %0d", $time,
                   $signed(m_axis_tdata), m_axis_tuser);
          errors++;
        end else begin
          zs_result_t e;
          e = expected_results.pop_front();
          if (e.norm !== m_axis_tdata)
            $display("%0t: normalized expected %0d actual %0d", $time,
                     $signed(e.norm), $signed(m_axis_tdata));
          if (e.status !== m_axis_tuser)
            $display("%0t: status expected %0d actual %0d", $time,
                     e.status, m_axis_tuser);
          if (e.norm !== m_axis_tdata || e.status !== m_axis_tuser) errors++;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [31:0] rand_value(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(4000)) - 2000);
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return 32'($urandom_range(1) ? 32'h7fffff00 : 32'h80000100)
                       + $urandom_range(255);
    endcase
  endfunction

  task automatic add_load(logic [31:0] v, logic lst);
    pending_items.push_back({FuncLoad, v, lst, IndexW'($urandom())});
  endtask

  task automatic add_read(logic [IndexW-1:0] ix);
    pending_items.push_back({FuncRead, $urandom(), 1'($urandom()), ix});
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() > 0 || !s_axis_tready) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_scale(logic [15:0] s);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= s;
    st_scale = s;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_sets(int n_items);
    int sent, len, mode;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) add_read(IndexW'($urandom()));
        else add_load(rand_value(0), 1'($urandom()));
        sent++;
        continue;
      end
      len  = $urandom_range(1, 12);
      mode = $urandom_range(3);
      for (int i = 0; i < len; i++) add_load(rand_value(mode), i == len - 1);
      for (int i = 0; i < len; i++) add_read(IndexW'($urandom_range(len)));
      sent += 2 * len;
    end
  endtask

  initial begin
    int phase_send[4] = '{0, 45, 0, 37};
    int phase_recv[4] = '{0, 0, 45, 37};
    logic [15:0] scales[4] = '{16'd1, 16'd65535, 16'd0, 16'd257};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    errors = 0;
    cycle_count = 0;
    hold_send = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    st_count = 0;
    st_mean = 0;
    st_dev = 32'd1 << FractionBitsDef;
    st_complete = 0;
    st_scale = ScaleReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: read before any set, equal values, tiny spread,
    // extremes, out of range index and a load after a completed set.
    add_read(10'd0);
    add_load(32'd5, 1'b0);
    add_load(32'd5, 1'b1);
    add_read(10'd0);
    add_read(10'd1);
    add_read(10'd2);
    add_load(32'h7fffffff, 1'b0);
    add_load(32'h80000000, 1'b0);
    add_load(32'd0, 1'b1);
    add_read(10'd0);
    add_read(10'd1);
    add_read(10'd2);
    add_read(10'h3ff);
    add_load(32'd0, 1'b0);
    add_load(32'd1, 1'b1);
    add_read(10'd0);
    add_read(10'd1);
    add_load(32'hfffffff0, 1'b1);
    add_read(10'd0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_scale(scales[ph]);
      send_idle_pct = phase_send[ph];
      recv_idle_pct = phase_recv[ph];
      random_sets(100);
      while (pending_items.size() > 60) @(posedge clk_i);
      hold_send = 1;
      while (expected_results.size() > 0 || s_axis_tvalid) @(posedge clk_i);
      hold_send = 0;
      drain();
    end
    set_scale(16'($urandom_range(1, 65535)));
    random_sets(40);
    drain();

    if (errors == 0) $display("zscore_normalize_saturate_core regression: pass");
    else $display("zscore_normalize_saturate_core regression: fail");
    $finish;
  end

  initial begin
    wait (cycle_count > 3000000);
    $display("zscore_normalize_saturate_core regression: fail");
    $finish;
  end
endmodule
